[hdl/srib_pkg.sv]
// Shared constants, widths and the arctangent table of the spherical range image binner.
package srib_pkg;

  localparam int IMAGE_WIDTH  = 1024;
  localparam int IMAGE_HEIGHT = 128;
  localparam int COL_W        = $clog2(IMAGE_WIDTH);
  localparam int ROW_W        = $clog2(IMAGE_HEIGHT);
  localparam int DEPTH        = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int ADDR_W       = $clog2(DEPTH);

  localparam int COORD_W      = 24;
  localparam int RANGE_W      = 24;
  localparam int COLIN_W      = 10;
  localparam int ROWIN_W      = 7;

  localparam int CORDIC_STEPS = 24;
  localparam int SQRT_STEPS   = 32;
  localparam int CNT_W        = 5;
  localparam int CD_W         = 52;
  localparam int ANG_W        = 34;
  localparam int ATAN_W       = 31;
  localparam int SQ_W         = 64;
  localparam int MULA_W       = 34;
  localparam int MULB_W       = 24;
  localparam int PROD_W       = MULA_W + MULB_W;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  // atan(2^-i) in units of 2^-32 turn.
  function automatic logic [ATAN_W-1:0] atan_turn(input logic [CNT_W-1:0] i);
    logic [ATAN_W-1:0] v;
    case (i)
      5'd0:  v = 31'd536870912;
      5'd1:  v = 31'd316933406;
      5'd2:  v = 31'd167458907;
      5'd3:  v = 31'd85004756;
      5'd4:  v = 31'd42667331;
      5'd5:  v = 31'd21354465;
      5'd6:  v = 31'd10679838;
      5'd7:  v = 31'd5340245;
      5'd8:  v = 31'd2670163;
      5'd9:  v = 31'd1335087;
      5'd10: v = 31'd667544;
      5'd11: v = 31'd333772;
      5'd12: v = 31'd166886;
      5'd13: v = 31'd83443;
      5'd14: v = 31'd41722;
      5'd15: v = 31'd20861;
      5'd16: v = 31'd10430;
      5'd17: v = 31'd5215;
      5'd18: v = 31'd2608;
      5'd19: v = 31'd1304;
      5'd20: v = 31'd652;
      5'd21: v = 31'd326;
      5'd22: v = 31'd163;
      5'd23: v = 31'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[hdl/srib_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module srib_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/spherical_range_image_binner_core.sv]
// Top level of the spherical range image binner: sequencer, shared units and pixel store.
//
//   Channel | Direction | Ports                                            | Handshake
//   in_     | input     | command, x_mm, y_mm, z_mm, read_column, read_row | in_valid / in_stall
//   out_    | output    | range_mm, pixel_filled                           | out_valid / out_stall
//
// An insert item keeps in_stall high from acceptance while it runs its steps in order: the
// squares on the shared multiplier, the range square root and its rounding, the horizontal
// square root, the two CORDIC passes, then binning and the read-modify-write of the pixel.
// A point at the origin ends after the rounding. The shared square root and CORDIC units
// make these steps run one after another.
// A read item keeps in_stall high through the states S_RD1 and S_RD2, and longer while a
// previous result still waits on out_stall.
// After reset the store is cleared one pixel a cycle, with in_stall held high.
// The output register lets a new item be accepted while a result waits to be taken.
module spherical_range_image_binner_core
  import srib_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_command,
  input  logic signed [COORD_W-1:0] in_x_mm,
  input  logic signed [COORD_W-1:0] in_y_mm,
  input  logic signed [COORD_W-1:0] in_z_mm,
  input  logic [COLIN_W-1:0]        in_read_column,
  input  logic [ROWIN_W-1:0]        in_read_row,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [RANGE_W-1:0]        out_range_mm,
  output logic                      out_pixel_filled
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_MUL, S_SQR1, S_RND, S_SQR2, S_CRD1, S_CRD2,
    S_COL, S_ROW, S_ADDR, S_RMW1, S_RMW2, S_RD1, S_RD2
  } state_t;

  state_t state_r;
  logic [CNT_W-1:0] cnt_r;
  logic [ADDR_W-1:0] addr_r;
  logic oor_r;
  logic out_valid_r;
  logic [RANGE_W-1:0] out_range_r;
  logic out_filled_r;

  logic signed [COORD_W-1:0] x_r, y_r, z_r;
  logic [PROD_W-1:0] prod_r;
  logic [SQ_W-1:0] hsq_r;
  logic [SQ_W-1:0] sq_v_r, sq_res_r;
  logic [RANGE_W-1:0] r_r;
  logic signed [CD_W-1:0] cx_r, cy_r;
  logic signed [ANG_W-1:0] cz_r;
  logic a_neg_r, b_neg_r;
  logic signed [ANG_W-1:0] azim_r;
  logic [COL_W-1:0] col_r;

  logic [RANGE_W-1:0] rdata;
  logic ram_we;
  logic [RANGE_W-1:0] ram_wdata;

  // Magnitudes of the coordinates; the most negative value maps to 2^23 correctly.
  logic [COORD_W-1:0] ax, ay, az;
  assign ax = x_r[COORD_W-1] ? COORD_W'(-x_r) : COORD_W'(x_r);
  assign ay = y_r[COORD_W-1] ? COORD_W'(-y_r) : COORD_W'(y_r);
  assign az = z_r[COORD_W-1] ? COORD_W'(-z_r) : COORD_W'(z_r);

  // Shared multiplier.
  logic [MULA_W-1:0] mul_a;
  logic [MULB_W-1:0] mul_b;
  logic [PROD_W-1:0] mul_p;
  logic signed [ANG_W-1:0] elev_w;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MUL: begin
        case (cnt_r)
          5'd0: begin mul_a = MULA_W'(ax); mul_b = MULB_W'(ax); end
          5'd1: begin mul_a = MULA_W'(az); mul_b = MULB_W'(az); end
          5'd2: begin mul_a = MULA_W'(ay); mul_b = MULB_W'(ay); end
          default: ;
        endcase
      end
      S_COL: begin
        mul_a = MULA_W'(azim_r + ANG_W'(64'sd2147483648));
        mul_b = MULB_W'(IMAGE_WIDTH);
      end
      S_ROW: begin
        mul_a = MULA_W'(elev_w + ANG_W'(64'sd1073741824));
        mul_b = MULB_W'(IMAGE_HEIGHT);
      end
      default: ;
    endcase
  end
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Shared square root unit: one result bit per cycle, remainder left in sq_v_r.
  logic [SQ_W-1:0] sq_bit, sq_trial;
  logic sq_ge;
  assign sq_bit   = SQ_W'(1) << (6'd62 - {cnt_r, 1'b0});
  assign sq_trial = sq_res_r + sq_bit;
  assign sq_ge    = sq_v_r >= sq_trial;

  // Round to nearest: one up when the remainder exceeds the floor root.
  logic [SQ_W-1:0] r_round;
  assign r_round = sq_res_r + SQ_W'(sq_v_r > sq_res_r);

  // Shared CORDIC vectoring unit.
  function automatic logic signed [CD_W-1:0] shr_s(input logic signed [CD_W-1:0] v,
                                                   input logic [CNT_W-1:0] s);
    logic [CD_W-1:0] m;
    m = v[CD_W-1] ? CD_W'(-v) : CD_W'(v);
    m = m >> s;
    return v[CD_W-1] ? -$signed(m) : $signed(m);
  endfunction

  logic signed [CD_W-1:0] cd_dx, cd_dy, cx_nxt, cy_nxt;
  logic signed [ANG_W-1:0] cz_nxt, atan_w;
  logic cd_pos;
  assign cd_dx  = shr_s(cy_r, cnt_r);
  assign cd_dy  = shr_s(cx_r, cnt_r);
  assign cd_pos = cy_r > 0;
  assign atan_w = $signed(ANG_W'(atan_turn(cnt_r)));
  assign cx_nxt = cd_pos ? cx_r + cd_dx : cx_r - cd_dx;
  assign cy_nxt = cd_pos ? cy_r - cd_dy : cy_r + cd_dy;
  assign cz_nxt = cd_pos ? cz_r + atan_w : cz_r - atan_w;

  // Clamp the first-quadrant angle, then unfold it by the operand signs.
  logic signed [ANG_W-1:0] ang_fin;
  always_comb begin
    ang_fin = cz_nxt;
    if (ang_fin < 0) begin
      ang_fin = '0;
    end
    if (ang_fin > ANG_W'(64'sd1073741824)) begin
      ang_fin = ANG_W'(64'sd1073741824);
    end
    if (b_neg_r) begin
      ang_fin = ANG_W'(64'sd2147483648) - ang_fin;
    end
    if (a_neg_r) begin
      ang_fin = -ang_fin;
    end
  end
  // After the elevation pass the angle sits in cz_r, already unfolded.
  assign elev_w = cz_r;

  // Binning: round half up, and an index equal to the image size wraps to zero.
  logic [PROD_W-1:0] col_sum, row_sum;
  logic [COL_W:0] col_v;
  logic [ROW_W:0] row_v;
  logic [COL_W-1:0] col_w;
  logic [ROW_W-1:0] row_w;
  assign col_sum = prod_r + PROD_W'(64'd2147483648);
  assign row_sum = prod_r + PROD_W'(64'd1073741824);
  assign col_v   = (COL_W+1)'(col_sum >> 32);
  assign row_v   = (ROW_W+1)'(row_sum >> 31);
  assign col_w   = (32'(col_v) >= IMAGE_WIDTH) ? '0 : COL_W'(col_v);
  assign row_w   = (32'(row_v) >= IMAGE_HEIGHT) ? '0 : ROW_W'(row_v);

  logic in_fire, rd_done, in_range;
  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign in_range = (32'(in_read_column) < IMAGE_WIDTH) && (32'(in_read_row) < IMAGE_HEIGHT);
  assign rd_done  = (state_r == S_RD2) && (!out_valid_r || !out_stall);

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = '0;
    case (state_r)
      S_CLR: ram_we = 1'b1;
      S_RD2: ram_we = rd_done && !oor_r;
      S_RMW2: begin
        ram_we    = (rdata == '0) || (r_r < rdata);
        ram_wdata = r_r;
      end
      default: ;
    endcase
  end

  srib_ram #(
    .WIDTH(RANGE_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(addr_r),
    .wdata(ram_wdata),
    .raddr(addr_r),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cnt_r       <= '0;
      addr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // A result stays until it is taken; a finished read loads a new one.
      out_valid_r <= rd_done || (out_valid_r && out_stall);
      case (state_r)
        S_CLR: begin
          addr_r <= addr_r + ADDR_W'(1);
          if (32'(addr_r) == DEPTH - 1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            cnt_r   <= '0;
            x_r     <= in_x_mm;
            y_r     <= in_y_mm;
            z_r     <= in_z_mm;
            oor_r   <= !in_range;
            addr_r  <= ADDR_W'(32'(in_read_row) * IMAGE_WIDTH + 32'(in_read_column));
            state_r <= (in_command == CMD_READ) ? S_RD1 : S_MUL;
          end
        end
        S_MUL: begin
          prod_r <= mul_p;
          case (cnt_r)
            5'd1: hsq_r <= SQ_W'(prod_r);
            5'd2: hsq_r <= hsq_r + SQ_W'(prod_r);
            default: ;
          endcase
          if (cnt_r == CNT_W'(3)) begin
            sq_v_r   <= hsq_r + SQ_W'(prod_r);
            sq_res_r <= '0;
            cnt_r    <= '0;
            state_r  <= S_SQR1;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        S_SQR1, S_SQR2: begin
          if (sq_ge) begin
            sq_v_r   <= sq_v_r - sq_trial;
            sq_res_r <= (sq_res_r >> 1) + sq_bit;
          end else begin
            sq_res_r <= sq_res_r >> 1;
          end
          if (32'(cnt_r) == SQRT_STEPS - 1) begin
            cnt_r <= '0;
            if (state_r == S_SQR1) begin
              state_r <= S_RND;
            end else begin
              // Azimuth pass: atan2(x, z).
              cx_r    <= $signed(CD_W'(az) << 24);
              cy_r    <= $signed(CD_W'(ax) << 24);
              cz_r    <= '0;
              a_neg_r <= x_r[COORD_W-1];
              b_neg_r <= z_r[COORD_W-1];
              state_r <= S_CRD1;
            end
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        S_RND: begin
          // A point at the origin has no range and is dropped.
          if (r_round == '0) begin
            state_r <= S_IDLE;
          end else begin
            r_r      <= RANGE_W'(r_round);
            sq_v_r   <= hsq_r << 16;
            sq_res_r <= '0;
            state_r  <= S_SQR2;
          end
        end
        S_CRD1, S_CRD2: begin
          if (32'(cnt_r) == CORDIC_STEPS - 1) begin
            cnt_r <= '0;
            if (state_r == S_CRD1) begin
              azim_r  <= ang_fin;
              // Elevation pass: atan2(y, h), with the root that holds h times 2^8 shifted to y's scale.
              cx_r    <= $signed(CD_W'(sq_res_r[31:0]) << 16);
              cy_r    <= $signed(CD_W'(ay) << 24);
              cz_r    <= '0;
              a_neg_r <= y_r[COORD_W-1];
              b_neg_r <= 1'b0;
              state_r <= S_CRD2;
            end else begin
              cz_r    <= ang_fin;
              state_r <= S_COL;
            end
          end else begin
            cx_r  <= cx_nxt;
            cy_r  <= cy_nxt;
            cz_r  <= cz_nxt;
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        S_COL: begin
          prod_r  <= mul_p;
          state_r <= S_ROW;
        end
        S_ROW: begin
          col_r   <= col_w;
          prod_r  <= mul_p;
          state_r <= S_ADDR;
        end
        S_ADDR: begin
          addr_r  <= ADDR_W'(32'(row_w) * IMAGE_WIDTH + 32'(col_r));
          state_r <= S_RMW1;
        end
        S_RMW1: state_r <= S_RMW2;
        S_RMW2: state_r <= S_IDLE;
        S_RD1:  state_r <= S_RD2;
        S_RD2: begin
          if (rd_done) begin
            out_range_r  <= oor_r ? '0 : rdata;
            out_filled_r <= !oor_r && (rdata != '0);
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_range_mm     = out_range_r;
  assign out_pixel_filled = out_filled_r;

endmodule

[hdl/srib_checker.sv]
// Port-level checks of the spherical range image binner, bound to the top level.
module srib_checker
  import srib_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               in_command,
  input logic               out_valid,
  input logic               out_stall,
  input logic [RANGE_W-1:0] out_range_mm,
  input logic               out_pixel_filled
);

  // Reset leaves no result pending.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // The block works on one item at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while busy");

  // An insert never produces a result.
  a_insert_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_command == CMD_INSERT && !out_valid |=> !out_valid)
    else $error("insert produced a result");

  // A filled pixel carries a nonzero range, an empty one a zero range.
  a_filled_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pixel_filled == (out_range_mm != '0)))
    else $error("pixel_filled disagrees with range_mm");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_range_mm) && $stable(out_pixel_filled))
    else $error("stalled result changed");

endmodule

bind spherical_range_image_binner_core srib_checker u_srib_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_command      (in_command),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_range_mm    (out_range_mm),
  .out_pixel_filled(out_pixel_filled)
);
